### rtl/crc8_packet_sender_with_retry_assert.svh
// Assertion macros shared by the checker of the CRC-8 frame sender.
// Depends on nothing; take in by `include with the bare file name.
`ifndef CRC8_PACKET_SENDER_WITH_RETRY_ASSERT_SVH
`define CRC8_PACKET_SENDER_WITH_RETRY_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRC8PS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CRC8PS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/crc8ps_pkg.sv
// Shared types, codes and helper functions for the CRC-8 frame sender.
// No dependencies.
package crc8ps_pkg;

	// request selector codes
	localparam logic [1:0] FUNC_SEND = 2'd0;
	localparam logic [1:0] FUNC_RX   = 2'd1;
	localparam logic [1:0] FUNC_TICK = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_BUSY = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_START   = 2'd0;
	localparam logic [1:0] REG_STOP    = 2'd1;
	localparam logic [1:0] REG_RETRY   = 2'd2;
	localparam logic [1:0] REG_ACK_MIN = 2'd3;

	localparam int CFG_DW = 16;

	localparam logic [7:0]  START_RST   = 8'h30;
	localparam logic [7:0]  STOP_RST    = 8'h20;
	localparam logic [15:0] RETRY_RST   = 16'd500;
	localparam logic [2:0]  ACK_MIN_RST = 3'd4;

	localparam logic [7:0] CRC_POLY  = 8'h07;
	localparam int         FRAME_LEN = 10;
	localparam int         QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [7:0]  start_marker;
		logic [7:0]  stop_marker;
		logic [15:0] retry_ticks;
		logic [2:0]  ack_min_ones;
	} cfg_t;

	// one queued command: a frame to send or a single result
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  msg_id;
		logic [7:0]  sensor;
		logic [7:0]  dtype;
		logic [31:0] payload;
	} cmd_t;

	function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	// set bits among the low seven, bit 7 ignored
	function automatic logic [2:0] ones7(logic [7:0] b);
		logic [2:0] n;
		n = 3'd0;
		for (int k = 0; k < 7; k++) begin
			n = n + {2'b00, b[k]};
		end
		return n;
	endfunction

endpackage

### rtl/crc8_packet_sender_with_retry.sv
// Stop-and-wait CRC-8 frame sender: each request, received byte or tick is
// one input transaction; results are frame bytes or single status results.
// The accepted command passes the queue, and the back part registers the first result.
// Throughput: one input per cycle while the command queue has room; one
// result per cycle while out_ready is high; a frame holds the back part for ten bytes.
// Reset (async, active low) empties queue and output, registers to defaults.
module crc8_packet_sender_with_retry #(
	parameter int QUEUE_DEPTH = crc8ps_pkg::QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [crc8ps_pkg::CFG_DW-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  func,
	input  logic [7:0]                  sensor_no,
	input  logic [7:0]                  payload_type,
	input  logic [31:0]                 payload,
	input  logic [7:0]                  rx_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  kind,
	output logic [7:0]                  tx_byte,
	output logic                        last
);
	crc8ps_pkg::cfg_t cfg_q;
	crc8ps_pkg::cmd_t push_cmd, head;
	logic push, pop, full, nonempty, take;

	assign in_ready = !full;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_marker <= crc8ps_pkg::START_RST;
			cfg_q.stop_marker  <= crc8ps_pkg::STOP_RST;
			cfg_q.retry_ticks  <= crc8ps_pkg::RETRY_RST;
			cfg_q.ack_min_ones <= crc8ps_pkg::ACK_MIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				crc8ps_pkg::REG_START:   cfg_q.start_marker <= cfg_data[7:0];
				crc8ps_pkg::REG_STOP:    cfg_q.stop_marker  <= cfg_data[7:0];
				crc8ps_pkg::REG_RETRY:   cfg_q.retry_ticks  <= cfg_data[15:0];
				crc8ps_pkg::REG_ACK_MIN: cfg_q.ack_min_ones <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	crc8ps_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.take         (take),
		.func         (func),
		.sensor_no    (sensor_no),
		.payload_type (payload_type),
		.payload      (payload),
		.rx_byte      (rx_byte),
		.push         (push),
		.push_cmd     (push_cmd)
	);

	crc8ps_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (full),
		.nonempty (nonempty),
		.head     (head)
	);

	crc8ps_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_nonempty (nonempty),
		.q_head     (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.tx_byte    (tx_byte),
		.last       (last)
	);

endmodule

### rtl/crc8ps_fifo.sv
// Short command queue between the front and back parts.
// Depends on crc8ps_pkg.
module crc8ps_fifo #(
	parameter int DEPTH = crc8ps_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  crc8ps_pkg::cmd_t  push_cmd,
	input  logic              pop,
	output logic              full,
	output logic              nonempty,
	output crc8ps_pkg::cmd_t  head
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	crc8ps_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	function automatic logic [PW-1:0] bump(logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign full     = (cnt_q == CW'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= bump(wr_ptr_q);
			if (pop)  rd_ptr_q <= bump(rd_ptr_q);
			if (push && !pop)      cnt_q <= cnt_q + CW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_cmd;
	end

endmodule

### rtl/crc8ps_front.sv
// Front part: takes requests, keeps the retry state and queues commands.
// Depends on crc8ps_pkg.
module crc8ps_front (
	input  logic              clk,
	input  logic              arst_n,
	input  crc8ps_pkg::cfg_t  cfg,
	input  logic              take,
	input  logic [1:0]        func,
	input  logic [7:0]        sensor_no,
	input  logic [7:0]        payload_type,
	input  logic [31:0]       payload,
	input  logic [7:0]        rx_byte,
	output logic              push,
	output crc8ps_pkg::cmd_t  push_cmd
);
	logic        busy_q, ack_q;
	logic [15:0] tick_q;
	logic [7:0]  cnt_q, sensor_q, dtype_q;
	logic [31:0] payload_q;
	logic [15:0] tick_nxt;
	logic        expire;

	assign tick_nxt = tick_q + 16'd1;
	assign expire   = (tick_nxt >= cfg.retry_ticks);

	always_comb begin
		push     = 1'b0;
		push_cmd = '{kind: crc8ps_pkg::KIND_BYTE, msg_id: cnt_q, sensor: sensor_q,
			dtype: dtype_q, payload: payload_q};
		case (func)
			crc8ps_pkg::FUNC_SEND: begin
				push = take;
				if (busy_q) begin
					push_cmd.kind = crc8ps_pkg::KIND_BUSY;
				end else begin
					push_cmd.msg_id  = cnt_q + 8'd1;
					push_cmd.sensor  = sensor_no;
					push_cmd.dtype   = payload_type;
					push_cmd.payload = payload;
				end
			end
			crc8ps_pkg::FUNC_TICK: begin
				push = take && busy_q && expire;
				if (ack_q) push_cmd.kind = crc8ps_pkg::KIND_DONE;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			ack_q     <= 1'b0;
			tick_q    <= '0;
			cnt_q     <= '0;
			sensor_q  <= '0;
			dtype_q   <= '0;
			payload_q <= '0;
		end else if (take) begin
			case (func)
				crc8ps_pkg::FUNC_SEND: begin
					if (!busy_q) begin
						busy_q    <= 1'b1;
						ack_q     <= 1'b0;
						tick_q    <= '0;
						cnt_q     <= cnt_q + 8'd1;
						sensor_q  <= sensor_no;
						dtype_q   <= payload_type;
						payload_q <= payload;
					end
				end
				crc8ps_pkg::FUNC_RX: begin
					ack_q <= (crc8ps_pkg::ones7(rx_byte) >= cfg.ack_min_ones);
				end
				crc8ps_pkg::FUNC_TICK: begin
					if (busy_q) begin
						// restart the period on expiry; drop busy at an expiry once acknowledged
						tick_q <= expire ? 16'd0 : tick_nxt;
						if (expire && ack_q) busy_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

### rtl/crc8ps_back.sv
// Back part: turns queued commands into result transactions, one per cycle while
// out_ready is high, computing the CRC as the frame goes out. Depends on crc8ps_pkg.
module crc8ps_back (
	input  logic              clk,
	input  logic              arst_n,
	input  crc8ps_pkg::cfg_t  cfg,
	input  logic              q_nonempty,
	input  crc8ps_pkg::cmd_t  q_head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        kind,
	output logic [7:0]        tx_byte,
	output logic              last
);
	localparam logic [3:0] LAST_IDX = 4'(crc8ps_pkg::FRAME_LEN - 1);

	logic              out_valid_q, active_q;
	logic [3:0]        idx_q;
	logic [7:0]        crc_q;
	crc8ps_pkg::cmd_t  cur_q;
	logic [1:0]        kind_q;
	logic [7:0]        tx_q;
	logic              last_q;
	logic              adv;
	logic [7:0]        fbyte;

	assign adv = !out_valid_q || out_ready;
	assign pop = adv && !active_q && q_nonempty;

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign tx_byte   = tx_q;
	assign last      = last_q;

	always_comb begin
		case (idx_q)
			4'd1:    fbyte = cur_q.msg_id;
			4'd2:    fbyte = cur_q.sensor;
			4'd3:    fbyte = cur_q.dtype;
			4'd4:    fbyte = cur_q.payload[7:0];
			4'd5:    fbyte = cur_q.payload[15:8];
			4'd6:    fbyte = cur_q.payload[23:16];
			4'd7:    fbyte = cur_q.payload[31:24];
			4'd8:    fbyte = crc_q;
			4'd9:    fbyte = cfg.stop_marker;
			default: fbyte = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			active_q    <= 1'b0;
			idx_q       <= '0;
		end else if (adv) begin
			if (active_q) begin
				out_valid_q <= 1'b1;
				idx_q       <= idx_q + 4'd1;
				if (idx_q == LAST_IDX) active_q <= 1'b0;
			end else if (q_nonempty) begin
				out_valid_q <= 1'b1;
				if (q_head.kind == crc8ps_pkg::KIND_BYTE) begin
					active_q <= 1'b1;
					idx_q    <= 4'd1;
				end
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (active_q) begin
				kind_q <= crc8ps_pkg::KIND_BYTE;
				tx_q   <= fbyte;
				last_q <= (idx_q == LAST_IDX);
				crc_q  <= crc8ps_pkg::crc8_step(crc_q, fbyte);
			end else if (q_nonempty) begin
				kind_q <= q_head.kind;
				if (q_head.kind == crc8ps_pkg::KIND_BYTE) begin
					// hold the frame fields and open with the start marker
					cur_q  <= q_head;
					crc_q  <= 8'd0;
					tx_q   <= cfg.start_marker;
					last_q <= 1'b0;
				end else begin
					tx_q   <= 8'd0;
					last_q <= 1'b1;
				end
			end
		end
	end

endmodule

### rtl/crc8ps_checker.sv
// Port-level checker for the CRC-8 frame sender, bound to the top level.
// Depends on crc8ps_pkg and crc8_packet_sender_with_retry_assert.svh.
`include "crc8_packet_sender_with_retry_assert.svh"

module crc8ps_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] kind,
	input logic [7:0] tx_byte,
	input logic       last
);
	`CRC8PS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(kind) && $stable(tx_byte) && $stable(last), "result changed while stalled")
	`CRC8PS_ASSERT_NOW(a_single_last, clk, arst_n, out_valid && kind != crc8ps_pkg::KIND_BYTE, last && tx_byte == 8'd0, "single result not flagged last or byte not zero")
	`CRC8PS_ASSERT_NOW(a_kind_legal, clk, arst_n, out_valid, kind == crc8ps_pkg::KIND_BYTE || kind == crc8ps_pkg::KIND_DONE || kind == crc8ps_pkg::KIND_BUSY, "illegal result kind")
	`CRC8PS_ASSERT_NEXT(a_frame_burst, clk, arst_n, out_valid && out_ready && kind == crc8ps_pkg::KIND_BYTE && !last, out_valid && kind == crc8ps_pkg::KIND_BYTE, "gap inside a frame")

endmodule

bind crc8_packet_sender_with_retry crc8ps_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.kind      (kind),
	.tx_byte   (tx_byte),
	.last      (last)
);

### tb/sv/crc8_packet_sender_with_retry_checker.sv
`timescale 1ns / 100ps
// Checker for the CRC-8 frame sender: watches register writes, requests and results,
// keeps its own model of the sender and compares each result in order.
// Depends on crc8ps_pkg for selector, kind and register codes and the frame length.
module crc8_packet_sender_with_retry_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  func,
	input  logic [7:0]  sensor_no,
	input  logic [7:0]  payload_type,
	input  logic [31:0] payload,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  tx_byte,
	input  logic        last,
	output int          fails,
	output int          outstanding,
	output int          checked
);

	localparam logic [7:0] GEN_POLY = 8'h07;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] tx_byte;
		logic       last;
	} result_t;

	result_t results_due[$];

	// register copies
	logic [7:0]  start_mark;
	logic [7:0]  stop_mark;
	logic [15:0] retry_period;
	logic [2:0]  ack_threshold;

	// sender state
	logic        sending;
	logic        acked;
	logic [15:0] tick_cnt;
	logic [7:0]  msg_id;
	logic [7:0]  frame_sensor;
	logic [7:0]  frame_type;
	logic [31:0] frame_word;
	logic [7:0]  frame_crc;

	int mismatches;
	int results_checked;

	// bitwise MSB-first CRC-8, no reflection
	function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] r;
		logic       fb;
		r = acc;
		for (int i = 7; i >= 0; i--) begin
			fb = r[7] ^ b[i];
			r = {r[6:0], 1'b0} ^ (fb ? GEN_POLY : 8'h00);
		end
		return r;
	endfunction

	function void queue_frame();
		logic [79:0] bytes;
		bytes = {start_mark, msg_id, frame_sensor, frame_type, frame_word[7:0],
			frame_word[15:8], frame_word[23:16], frame_word[31:24], frame_crc, stop_mark};
		for (int i = 0; i < crc8ps_pkg::FRAME_LEN; i++) begin
			results_due.push_back('{crc8ps_pkg::KIND_BYTE, bytes[79 - 8 * i -: 8],
				i == crc8ps_pkg::FRAME_LEN - 1});
		end
	endfunction

	function void predict_transaction(input logic [1:0] f, input logic [7:0] sid,
			input logic [7:0] dt, input logic [31:0] word, input logic [7:0] rb);
		logic [7:0] c;
		case (f)
			crc8ps_pkg::FUNC_SEND: begin
				if (sending) begin
					results_due.push_back('{crc8ps_pkg::KIND_BUSY, 8'h00, 1'b1});
				end else begin
					msg_id = msg_id + 8'd1;
					frame_sensor = sid;
					frame_type = dt;
					frame_word = word;
					c = crc8_byte(8'h00, msg_id);
					c = crc8_byte(c, sid);
					c = crc8_byte(c, dt);
					c = crc8_byte(c, word[7:0]);
					c = crc8_byte(c, word[15:8]);
					c = crc8_byte(c, word[23:16]);
					frame_crc = crc8_byte(c, word[31:24]);
					sending = 1'b1;
					acked = 1'b0;
					tick_cnt = '0;
					queue_frame();
				end
			end
			crc8ps_pkg::FUNC_RX: begin
				// bit 7 never counts
				acked = $countones(rb[6:0]) >= ack_threshold;
			end
			crc8ps_pkg::FUNC_TICK: begin
				if (sending) begin
					tick_cnt = tick_cnt + 16'd1;
					if (tick_cnt >= retry_period) begin
						tick_cnt = '0;
						if (acked) begin
							sending = 1'b0;
							results_due.push_back('{crc8ps_pkg::KIND_DONE, 8'h00, 1'b1});
						end else begin
							queue_frame();
						end
					end
				end
			end
			default: ;
		endcase
	endfunction

	function void compare_result(input logic [1:0] k, input logic [7:0] b, input logic l);
		result_t want;
		results_checked++;
		if (results_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%t: result with nothing due: kind %0d byte %02h last %0b",
					$time, k, b, l);
		end else begin
			want = results_due.pop_front();
			if (want.kind !== k || want.tx_byte !== b || want.last !== l) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%t: result %0d: expected kind %0d byte %02h last %0b, %s",
						$time, results_checked, want.kind, want.tx_byte, want.last,
						$sformatf("got kind %0d byte %02h last %0b", k, b, l));
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_mark = 8'h30;
			stop_mark = 8'h20;
			retry_period = 16'd500;
			ack_threshold = 3'd4;
			sending = 1'b0;
			acked = 1'b0;
			tick_cnt = '0;
			msg_id = '0;
			frame_sensor = '0;
			frame_type = '0;
			frame_word = '0;
			frame_crc = '0;
			mismatches = 0;
			results_checked = 0;
			results_due.delete();
			fails <= 0;
			outstanding <= 0;
			checked <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					crc8ps_pkg::REG_START: start_mark = cfg_data[7:0];
					crc8ps_pkg::REG_STOP: stop_mark = cfg_data[7:0];
					crc8ps_pkg::REG_RETRY: retry_period = cfg_data[15:0];
					crc8ps_pkg::REG_ACK_MIN: ack_threshold = cfg_data[2:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				predict_transaction(func, sensor_no, payload_type, payload, rx_byte);
			if (out_valid && out_ready)
				compare_result(kind, tx_byte, last);
			fails <= mismatches;
			outstanding <= results_due.size();
			checked <= results_checked;
		end
	end

endmodule

### tb/sv/tb_crc8_packet_sender_with_retry.sv
`timescale 1ns / 100ps
// Top of the CRC-8 frame sender testbench: clock, reset, register writes, request
// stimulus and result back-pressure. Needs crc8ps_pkg, the sender and its checker.
module tb_crc8_packet_sender_with_retry;

	// selector value the sender ignores
	localparam logic [1:0] FUNC_NONE = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  func;
	logic [7:0]  sensor_no;
	logic [7:0]  payload_type;
	logic [31:0] payload;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  kind;
	logic [7:0]  tx_byte;
	logic        last;

	int fails;
	int outstanding;
	int checked;

	logic        hold_long;
	bit          quick = 1'b0;
	logic [15:0] cur_retry = 16'd500;
	int          n_send = 0;
	int          n_rx = 0;
	int          n_tick = 0;
	int          n_none = 0;
	int          settings = 1;
	int          leftover = 0;

	crc8_packet_sender_with_retry dut (.*);

	crc8_packet_sender_with_retry_checker frame_check (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("Timeout at %t", $time);
		$display("Regression FAIL");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_gap();
		int r;
		r = int'($urandom_range(0, 99));
		if (r < 55)
			return 0;
		if (r < 90)
			return int'($urandom_range(1, 3));
		return int'($urandom_range(8, 40));
	endfunction

	task automatic send_item(input logic [1:0] f, input logic [7:0] sid, input logic [7:0] dt,
			input logic [31:0] word, input logic [7:0] rb);
		int gap;
		gap = quick ? 0 : idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		sensor_no <= sid;
		payload_type <= dt;
		payload <= word;
		rx_byte <= rb;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		case (f)
			crc8ps_pkg::FUNC_SEND: n_send++;
			crc8ps_pkg::FUNC_RX: n_rx++;
			crc8ps_pkg::FUNC_TICK: n_tick++;
			default: n_none++;
		endcase
	endtask

	// random content in the fields the selector does not use
	task automatic offer(input logic [1:0] f, input logic [7:0] rb);
		send_item(f, 8'($urandom), 8'($urandom), 32'($urandom), rb);
	endtask

	// wait for every due result, then for the pipeline to run dry
	task automatic settle();
		int waited;
		in_valid <= 1'b0;
		@(posedge clk);
		waited = 0;
		while (outstanding != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		if (outstanding != 0) begin
			$display("%t: %0d results never arrived", $time, outstanding);
			leftover += outstanding;
		end
		repeat (8) @(posedge clk);
	endtask

	// acknowledge and tick through a full period so the sender ends up idle
	task automatic finish_frame();
		int n;
		n = (cur_retry == 16'd0) ? 1 : int'(cur_retry);
		offer(crc8ps_pkg::FUNC_RX, 8'h7F);
		repeat (n) offer(crc8ps_pkg::FUNC_TICK, 8'($urandom));
		settle();
	endtask

	// upper data bits carry junk the narrow registers must drop
	task automatic set_config(input logic [7:0] sm, input logic [7:0] em,
			input logic [15:0] rt, input logic [2:0] am);
		cfg_we <= 1'b1;
		cfg_index <= crc8ps_pkg::REG_START;
		cfg_data <= {8'($urandom), sm};
		@(posedge clk);
		cfg_index <= crc8ps_pkg::REG_STOP;
		cfg_data <= {8'($urandom), em};
		@(posedge clk);
		cfg_index <= crc8ps_pkg::REG_RETRY;
		cfg_data <= rt;
		@(posedge clk);
		cfg_index <= crc8ps_pkg::REG_ACK_MIN;
		cfg_data <= {13'($urandom), am};
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_retry = rt;
		settings++;
	endtask

	task automatic random_phase(input int n);
		int count;
		int pick;
		count = 0;
		while (count < n) begin
			pick = int'($urandom_range(0, 99));
			if (pick < 20)
				send_item(crc8ps_pkg::FUNC_SEND, 8'($urandom), 8'($urandom), 32'($urandom),
					8'($urandom));
			else if (pick < 50)
				offer(crc8ps_pkg::FUNC_RX, 8'($urandom));
			else if (pick < 95)
				offer(crc8ps_pkg::FUNC_TICK, 8'($urandom));
			else
				offer(FUNC_NONE, 8'($urandom));
			count++;
		end
	endtask

	initial begin : result_sink
		int gap;
		int stretch;
		bit stalled_long;
		stalled_long = 1'b0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = idle_gap();
			if (hold_long && !stalled_long) begin
				gap = 300;
				stalled_long = 1'b1;
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			stretch = ($urandom_range(0, 9) == 0) ? int'($urandom_range(60, 120))
				: int'($urandom_range(1, 12));
			// cut the stretch short once the long hold-off is asked for
			repeat (stretch) begin
				@(posedge clk);
				if (hold_long && !stalled_long) break;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= crc8ps_pkg::REG_START;
		cfg_data <= '0;
		in_valid <= 1'b0;
		func <= crc8ps_pkg::FUNC_SEND;
		sensor_no <= '0;
		payload_type <= '0;
		payload <= '0;
		rx_byte <= '0;
		hold_long <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: markers, 500-tick period, four ones to acknowledge
		offer(crc8ps_pkg::FUNC_TICK, 8'($urandom));
		offer(FUNC_NONE, 8'($urandom));
		offer(crc8ps_pkg::FUNC_RX, 8'hFF);
		send_item(crc8ps_pkg::FUNC_SEND, 8'h00, 8'h00, 32'h0000_0000, 8'h00);
		send_item(crc8ps_pkg::FUNC_SEND, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
		offer(crc8ps_pkg::FUNC_RX, 8'h87);
		settle();
		// shorten the period of the frame still waiting
		set_config(8'hC3, 8'h3C, 16'd2, 3'd4);
		finish_frame();

		// one-tick period, every byte acknowledges
		set_config(8'h00, 8'hFF, 16'd1, 3'd0);
		send_item(crc8ps_pkg::FUNC_SEND, 8'hAA, 8'h55, 32'hA5A5_5A5A, 8'h00);
		offer(crc8ps_pkg::FUNC_TICK, 8'($urandom));
		offer(crc8ps_pkg::FUNC_RX, 8'h00);
		send_item(crc8ps_pkg::FUNC_SEND, 8'h33, 8'hCC, 32'h0F0F_F0F0, 8'h00);
		offer(crc8ps_pkg::FUNC_TICK, 8'($urandom));
		offer(crc8ps_pkg::FUNC_RX, 8'h80);
		send_item(crc8ps_pkg::FUNC_SEND, 8'h12, 8'h00, 32'h3F80_0000, 8'h00);
		offer(crc8ps_pkg::FUNC_TICK, 8'($urandom));
		finish_frame();

		// zero period expires on every tick; all seven low bits needed
		set_config(8'hFF, 8'h00, 16'd0, 3'd7);
		send_item(crc8ps_pkg::FUNC_SEND, 8'h01, 8'h01, 32'h8000_0001, 8'h00);
		offer(crc8ps_pkg::FUNC_RX, 8'h7F);
		offer(crc8ps_pkg::FUNC_RX, 8'hFE);
		offer(crc8ps_pkg::FUNC_TICK, 8'($urandom));
		offer(crc8ps_pkg::FUNC_RX, 8'hFF);
		offer(crc8ps_pkg::FUNC_TICK, 8'($urandom));
		offer(crc8ps_pkg::FUNC_TICK, 8'($urandom));
		finish_frame();

		// resent frame keeps the acknowledge state
		set_config(8'h7E, 8'h81, 16'd3, 3'd4);
		send_item(crc8ps_pkg::FUNC_SEND, 8'h5A, 8'h01, 32'h1234_5678, 8'h00);
		offer(crc8ps_pkg::FUNC_RX, 8'h0F);
		offer(crc8ps_pkg::FUNC_RX, 8'h8E);
		repeat (3) offer(crc8ps_pkg::FUNC_TICK, 8'($urandom));
		offer(crc8ps_pkg::FUNC_RX, 8'h1E);
		repeat (3) offer(crc8ps_pkg::FUNC_TICK, 8'($urandom));
		settle();

		// frames back to back; hold results off once meanwhile so the input stalls
		set_config(8'($urandom), 8'($urandom), 16'd1, 3'($urandom_range(0, 7)));
		hold_long <= 1'b1;
		repeat (12) begin
			send_item(crc8ps_pkg::FUNC_SEND, 8'($urandom), 8'($urandom), 32'($urandom),
				8'($urandom));
			offer(crc8ps_pkg::FUNC_RX, 8'h7F);
			offer(crc8ps_pkg::FUNC_TICK, 8'($urandom));
		end
		settle();

		// random traffic; the closing ticks of the last phase run without input gaps
		for (int p = 0; p < 2; p++) begin
			set_config(8'($urandom), 8'($urandom), 16'($urandom_range(1, 6)),
				3'($urandom_range(0, 7)));
			random_phase(20);
			quick = (p == 1);
			finish_frame();
			quick = 1'b0;
		end

		$display("Covered %0d sends, %0d received bytes, %0d ticks, %0d ignored selectors",
			n_send, n_rx, n_tick, n_none);
		$display("over %0d register settings; %0d results compared in order.", settings, checked);
		if (fails == 0 && leftover == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
